[hw/rtl/ihex_pkg.sv]
// shared constants, control-word type and microcode rom for the intel hex record encoder
// depends on nothing; used by intel_hex_record_encoder

package ihex_pkg;

	localparam int RECORD_BYTES = 16;
	localparam int COUNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int PC_W = 4;

	// byte source for the character being sent
	localparam logic [2:0] SRC_COLON   = 3'd0;
	localparam logic [2:0] SRC_COUNT   = 3'd1;
	localparam logic [2:0] SRC_ADDR_HI = 3'd2;
	localparam logic [2:0] SRC_ADDR_LO = 3'd3;
	localparam logic [2:0] SRC_ZERO    = 3'd4;
	localparam logic [2:0] SRC_DATA    = 3'd5;
	localparam logic [2:0] SRC_CHECK   = 3'd6;
	localparam logic [2:0] SRC_LF      = 3'd7;

	localparam logic [6:0] CHAR_COLON = 7'h3A;
	localparam logic [6:0] CHAR_LF    = 7'h0A;

	// program steps
	localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
	localparam logic [PC_W-1:0] ST_COLON    = 4'd1;
	localparam logic [PC_W-1:0] ST_CNT_H    = 4'd2;
	localparam logic [PC_W-1:0] ST_CNT_L    = 4'd3;
	localparam logic [PC_W-1:0] ST_AHI_H    = 4'd4;
	localparam logic [PC_W-1:0] ST_AHI_L    = 4'd5;
	localparam logic [PC_W-1:0] ST_ALO_H    = 4'd6;
	localparam logic [PC_W-1:0] ST_ALO_L    = 4'd7;
	localparam logic [PC_W-1:0] ST_TYPE_H   = 4'd8;
	localparam logic [PC_W-1:0] ST_TYPE_L   = 4'd9;
	localparam logic [PC_W-1:0] ST_DATA_H   = 4'd10;
	localparam logic [PC_W-1:0] ST_DATA_L   = 4'd11;
	localparam logic [PC_W-1:0] ST_CHK_H    = 4'd12;
	localparam logic [PC_W-1:0] ST_CHK_L    = 4'd13;
	localparam logic [PC_W-1:0] ST_LF       = 4'd14;

	typedef struct packed {
		logic [2:0]      src;
		logic            hi_nib;
		logic            last;
		logic            loop_data;  // jump to target while data bytes remain
		logic            done;       // record finished, back to wait
		logic [PC_W-1:0] target;
	} ucode_t;

	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{src: SRC_ZERO, hi_nib: 1'b0, last: 1'b0, loop_data: 1'b0, done: 1'b0,
			target: ST_WAIT};
		case (pc)
			ST_COLON:  w.src = SRC_COLON;
			ST_CNT_H:  begin w.src = SRC_COUNT; w.hi_nib = 1'b1; end
			ST_CNT_L:  w.src = SRC_COUNT;
			ST_AHI_H:  begin w.src = SRC_ADDR_HI; w.hi_nib = 1'b1; end
			ST_AHI_L:  w.src = SRC_ADDR_HI;
			ST_ALO_H:  begin w.src = SRC_ADDR_LO; w.hi_nib = 1'b1; end
			ST_ALO_L:  w.src = SRC_ADDR_LO;
			ST_TYPE_H: begin w.src = SRC_ZERO; w.hi_nib = 1'b1; end
			ST_TYPE_L: w.src = SRC_ZERO;
			ST_DATA_H: begin w.src = SRC_DATA; w.hi_nib = 1'b1; end
			ST_DATA_L: begin
				w.src = SRC_DATA;
				w.loop_data = 1'b1;
				w.target = ST_DATA_H;
			end
			ST_CHK_H:  begin w.src = SRC_CHECK; w.hi_nib = 1'b1; end
			ST_CHK_L:  w.src = SRC_CHECK;
			ST_LF:     begin w.src = SRC_LF; w.last = 1'b1; w.done = 1'b1; end
			default:   w.src = SRC_ZERO;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = 7'h30 + 7'(nib);
		end else begin
			c = 7'h37 + 7'(nib);
		end
		return c;
	endfunction

endpackage

[hw/rtl/intel_hex_record_encoder.sv]
// intel hex data record encoder: gathers bytes into records, sends each record as ascii text
// depends on ihex_pkg (constants, microcode rom, hex digit function)
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  in       | input     | in_valid/in_stall  | data_byte, end_of_data
//  out      | output    | out_valid/out_stall| ascii_char, last_char
//  apb      | input     | psel/penable/...   | start_address at address 0
//
// a byte that does not close a record is taken without a stall; one that closes a record
// is followed by 12 + 2*count characters (44 for a full record), sent by the sequencer
// one per cycle unless out_stall holds the output. in_stall is high while a record is sent.
// reset clears control state; the record buffer holds no reset value.
// a held out_stall freezes the sequencer, the single output register keeps its beat.

module intel_hex_record_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  ascii_char,
	output logic        last_char,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]                      buf_q [ihex_pkg::RECORD_BYTES];
	logic [ihex_pkg::COUNT_W-1:0]    count_q;
	logic [ihex_pkg::COUNT_W-1:0]    idx_q;
	logic [15:0]                     addr_q;
	logic [15:0]                     start_q;
	logic [7:0]                      chk_q;
	logic                            in_run_q;
	logic [ihex_pkg::PC_W-1:0]       pc_q;
	logic [6:0]                      char_q;
	logic                            last_q;
	logic                            ovalid_q;

	ihex_pkg::ucode_t                uw;
	logic                            accept;
	logic                            out_free;
	logic [ihex_pkg::COUNT_W-1:0]    cnt_base;
	logic [ihex_pkg::COUNT_W-1:0]    cnt_next;
	logic [7:0]                      chk_base;
	logic [7:0]                      sel_byte;
	logic [7:0]                      sum;
	logic [3:0]                      nib;
	logic [6:0]                      ch;
	logic                            more_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, start_q} : 32'd0;

	assign in_stall   = (pc_q != ihex_pkg::ST_WAIT);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !ovalid_q || !out_stall;
	assign out_valid  = ovalid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

	assign uw = ihex_pkg::ucode(pc_q);

	// a new run starts from an empty record
	assign cnt_base = in_run_q ? count_q : '0;
	assign chk_base = in_run_q ? chk_q : 8'd0;
	assign cnt_next = cnt_base + 1'b1;
	assign more_data = (idx_q + 1'b1) != count_q;

	assign sum = 8'(count_q) + addr_q[15:8] + addr_q[7:0] + chk_q;

	always_comb begin
		case (uw.src)
			ihex_pkg::SRC_COUNT:   sel_byte = 8'(count_q);
			ihex_pkg::SRC_ADDR_HI: sel_byte = addr_q[15:8];
			ihex_pkg::SRC_ADDR_LO: sel_byte = addr_q[7:0];
			ihex_pkg::SRC_DATA:    sel_byte = buf_q[idx_q[ihex_pkg::IDX_W-1:0]];
			ihex_pkg::SRC_CHECK:   sel_byte = 8'd0 - sum;
			default:               sel_byte = 8'd0;
		endcase
		nib = uw.hi_nib ? sel_byte[7:4] : sel_byte[3:0];
		if (uw.src == ihex_pkg::SRC_COLON) begin
			ch = ihex_pkg::CHAR_COLON;
		end else if (uw.src == ihex_pkg::SRC_LF) begin
			ch = ihex_pkg::CHAR_LF;
		end else begin
			ch = ihex_pkg::hex_char(nib);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[cnt_base[ihex_pkg::IDX_W-1:0]] <= data_byte;
		end
		if (pc_q != ihex_pkg::ST_WAIT && out_free) begin
			char_q <= ch;
			last_q <= uw.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 16'd0;
			addr_q   <= 16'd0;
			count_q  <= '0;
			idx_q    <= '0;
			chk_q    <= 8'd0;
			in_run_q <= 1'b0;
			pc_q     <= ihex_pkg::ST_WAIT;
			ovalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				start_q <= pwdata[15:0];
			end
			// output register takes a new beat or drains whenever it is free
			if (out_free) begin
				ovalid_q <= (pc_q != ihex_pkg::ST_WAIT);
			end
			if (pc_q == ihex_pkg::ST_WAIT) begin
				if (accept) begin
					if (!in_run_q) begin
						addr_q <= start_q;
					end
					count_q  <= cnt_next;
					chk_q    <= chk_base + data_byte;
					in_run_q <= !end_of_data;
					idx_q    <= '0;
					if (end_of_data || cnt_next >= ihex_pkg::COUNT_W'(ihex_pkg::RECORD_BYTES)) begin
						pc_q <= ihex_pkg::ST_COLON;
					end
				end
			end else if (out_free) begin
				if (uw.done) begin
					addr_q  <= addr_q + 16'(count_q);
					count_q <= '0;
					chk_q   <= 8'd0;
					pc_q    <= ihex_pkg::ST_WAIT;
				end else if (uw.loop_data && more_data) begin
					idx_q <= idx_q + 1'b1;
					pc_q  <= uw.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

[sim/intel_hex_record_encoder_tb.sv]
// testbench for intel_hex_record_encoder: directed and random byte runs, every output beat
// checked against a built-in predictor of the record text; needs ihex_pkg and the block rtl

module intel_hex_record_encoder_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int TARGET_ITEMS = 430;
	localparam int PHASES = 8;
	localparam int SETTLE_CYCLES = 5;
	localparam logic [2:0] ADDR_START = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	typedef struct {
		logic [6:0] ch;
		logic       lf;
	} text_char_t;

	class hex_record_scoreboard;
		logic [15:0] start_addr;
		logic [15:0] load_addr;
		logic [7:0]  rec_bytes [ihex_pkg::RECORD_BYTES];
		int          held;
		logic [7:0]  data_sum;
		bit          in_run;
		text_char_t  pending_chars [$];

		function new();
			start_addr = '0;
			load_addr = '0;
			held = 0;
			data_sum = '0;
			in_run = 1'b0;
		endfunction

		function void set_start(logic [15:0] a);
			start_addr = a;
		endfunction

		function logic [6:0] nib_to_ascii(logic [3:0] n);
			if (n < 4'd10)
				return 7'h30 + 7'(n);
			return 7'h41 + 7'(n) - 7'd10;
		endfunction

		function void push_char(logic [6:0] c, logic lf);
			text_char_t t;
			t.ch = c;
			t.lf = lf;
			pending_chars.push_back(t);
		endfunction

		function void push_hex(logic [7:0] v);
			push_char(nib_to_ascii(v[7:4]), 1'b0);
			push_char(nib_to_ascii(v[3:0]), 1'b0);
		endfunction

		// one data record: colon, count, address, type, data, checksum, line feed
		function void queue_record_text();
			logic [7:0] sum;
			sum = 8'(held) + load_addr[15:8] + load_addr[7:0] + data_sum;
			push_char(ihex_pkg::CHAR_COLON, 1'b0);
			push_hex(8'(held));
			push_hex(load_addr[15:8]);
			push_hex(load_addr[7:0]);
			push_hex(8'h00);
			for (int i = 0; i < held; i++)
				push_hex(rec_bytes[i]);
			push_hex(8'h00 - sum);
			push_char(ihex_pkg::CHAR_LF, 1'b1);
			load_addr = load_addr + 16'(held);
			held = 0;
			data_sum = '0;
		endfunction

		function void note_byte(logic [7:0] b, logic e);
			if (!in_run) begin
				load_addr = start_addr;
				held = 0;
				data_sum = '0;
				in_run = 1'b1;
			end
			rec_bytes[held] = b;
			held++;
			data_sum = data_sum + b;
			if (held >= ihex_pkg::RECORD_BYTES || e)
				queue_record_text();
			if (e)
				in_run = 1'b0;
		endfunction

		function string check_char(logic [6:0] ch, logic lf);
			text_char_t want;
			string msg;
			msg = "";
			if (pending_chars.size() == 0)
				return $sformatf("beat with nothing expected: char 0x%02h last %0b", ch, lf);
			want = pending_chars.pop_front();
			if (ch !== want.ch)
				msg = $sformatf("ascii_char 0x%02h, expected 0x%02h", ch, want.ch);
			if (lf !== want.lf)
				msg = {msg, (msg == "") ? "" : "; ",
					$sformatf("last_char %0b, expected %0b", lf, want.lf)};
			return msg;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_data;
	logic        out_valid;
	logic        out_stall;
	logic [6:0]  ascii_char;
	logic        last_char;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hex_record_scoreboard sb = new();
	int errors = 0;
	int idle_cycles = 0;
	bit fast_in = 1'b0;
	bit fast_out = 1'b0;

	intel_hex_record_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.end_of_data(end_of_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.last_char  (last_char),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_START)
			sb.set_start(value[15:0]);
		@(posedge clk);
	endtask

	task automatic apb_read_check();
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_START;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== {16'h0000, sb.start_addr})
			report_mismatch($sformatf("start_address read 0x%08h, expected 0x%04h",
				got, sb.start_addr));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		gap = fast_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_data <= e;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_byte(b, e);
	endtask

	// block is idle once all text is out; the settle wait also covers a byte that closes no record
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// optional address change between records of a run must not move the run
	task automatic send_run(input int len, input bit mid_write);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom), i == len - 1);
			if (mid_write && i == ihex_pkg::RECORD_BYTES - 1 && len > ihex_pkg::RECORD_BYTES) begin
				wait_idle();
				apb_write(ADDR_START, $urandom);
				apb_read_check();
			end
		end
	endtask

	initial begin
		int n;
		string msg;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = fast_out ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			msg = sb.check_char(ascii_char, last_char);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int sent;
		int phase_end;
		int len;
		int sel;
		logic [15:0] phase_addr [PHASES];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		end_of_data <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset value, a write, and a write to an unused address
		apb_read_check();
		apb_write(ADDR_START, 32'h0000_1234);
		apb_read_check();
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		apb_read_check();

		// one-byte record, then end mark landing on a full record
		send_byte(8'hFF, 1'b1);
		for (int i = 0; i < ihex_pkg::RECORD_BYTES; i++)
			send_byte(i[0] ? 8'hFF : 8'h00, i == ihex_pkg::RECORD_BYTES - 1);
		wait_idle();
		apb_write(ADDR_START, 32'h0000_FFFF);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		sent = ihex_pkg::RECORD_BYTES + 5;

		phase_addr = '{16'h0000, 16'hFFFF, 16'hFFF8, 16'hFFF0, 16'h8000,
			16'($urandom), 16'($urandom), 16'($urandom)};
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			apb_write(ADDR_START, {16'($urandom), phase_addr[p]});
			apb_read_check();
			fast_in = (p % 3 == 1);
			fast_out = (p % 3 == 2);
			phase_end = sent + (TARGET_ITEMS - sent) / (PHASES - p);
			while (sent < phase_end) begin
				sel = $urandom_range(0, 99);
				if (sel < 60)
					len = $urandom_range(1, 20);
				else if (sel < 80)
					len = ihex_pkg::RECORD_BYTES * $urandom_range(1, 3);
				else
					len = $urandom_range(21, 60);
				send_run(len, $urandom_range(0, 2) == 0);
				sent += len;
			end
		end

		in_valid <= 1'b0;
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
